FILE: src/adfx_pkg.sv
// Shared constants and types for the ASCII decimal to fixed-point converter.
// No dependencies; every other file of the block depends on this package.
package adfx_pkg;

  // Default number format: Q31.16 with five decimal fraction digits kept.
  localparam int INT_BITS_DEF    = 31;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int FRAC_DIGITS_DEF = 5;
  localparam int VALUE_W_DEF     = INT_BITS_DEF + FRAC_BITS_DEF + 1;

  localparam int CHAR_W = 8;
  localparam int DIGIT_W = 4;
  localparam int RADIX = 10;

  // Characters with a meaning of their own.
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

  // Status that travels with a number down the result pipeline.
  typedef struct packed {
    logic neg;
    logic ok;
    logic sat;
  } adfx_flags_t;

  // Power of ten, used on constants only.
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 1;
    for (int i = 0; i < n; i++) begin
      p = p * RADIX;
    end
    return p;
  endfunction

endpackage

FILE: src/adfx_in_if.sv
// Character channel of the ASCII decimal to fixed-point converter.
// Depends on adfx_pkg for the character width.
interface adfx_in_if;
  import adfx_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

FILE: src/adfx_out_if.sv
// Result channel of the ASCII decimal to fixed-point converter.
// Depends on adfx_pkg for the default value width.
interface adfx_out_if #(
  parameter int VALUE_W = adfx_pkg::VALUE_W_DEF
);
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic                      is_valid;
  logic                      overflowed;

  modport source (output valid, output value, output is_valid, output overflowed,
                  input ready);
  modport sink (input valid, input value, input is_valid, input overflowed,
                output ready);
endinterface

FILE: src/ascii_decimal_to_fixed_point_core.sv
// Top level of the ASCII decimal to fixed-point converter.
// Depends on adfx_pkg, adfx_in_if and adfx_out_if.
//
// This block reads a decimal number as a stream of ASCII characters, one per
// transaction on in_ch, and returns one signed fixed-point result per number
// on out_ch, with INT_BITS integer bits and FRAC_BITS fraction bits
// (Q31.16 by default, so the value field is INT_BITS + FRAC_BITS + 1 bits
// wide; the out_ch instance must be built with that VALUE_W). The character
// marked with last_char ends the number. A leading '-' negates the result and
// the first '.' starts the fraction; any other non-digit is taken as a zero
// digit and clears is_valid. The integer part saturates at 2^INT_BITS - 1 and
// sets overflowed. Only the first FRAC_DIGITS fraction digits count, and the
// fraction is truncated toward zero. A character is taken in every cycle while
// in_ch.ready is high: the running number is updated in the cycle of its
// transaction. The completed number then moves through the registers of the
// result pipeline: stage A captures it at the clock edge of the transaction
// of the last character, stage B scales the fraction with a split reciprocal
// multiply, stage C joins it to the integer part, and the output register
// applies the sign. The pipeline moves as a whole, so in_ch.ready is low only
// while the output register holds a result that out_ch has not taken. After a
// result the running number starts afresh.
module ascii_decimal_to_fixed_point_core #(
  parameter int INT_BITS    = adfx_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS   = adfx_pkg::FRAC_BITS_DEF,
  parameter int FRAC_DIGITS = adfx_pkg::FRAC_DIGITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  adfx_in_if.sink           in_ch,
  adfx_out_if.source        out_ch
);
  import adfx_pkg::*;

  // Width of the result.
  localparam int VW = INT_BITS + FRAC_BITS + 1;
  localparam int MAG_W = INT_BITS + FRAC_BITS;

  // The kept fraction digits, left-aligned to FRAC_DIGITS places, form an
  // integer below DEC_SCALE.
  localparam longint unsigned DEC_SCALE = pow10(FRAC_DIGITS);
  localparam int FW = $clog2(DEC_SCALE);
  localparam int CW = $clog2(FRAC_DIGITS + 1);
  localparam int IW = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;

  // The fraction bits are floor(f * 2^FRAC_BITS / DEC_SCALE). They come from
  // f * RECIP >> SHIFT_T, where RECIP is the rounded-up reciprocal. With
  // 2^SHIFT_T at least DEC_SCALE squared, the error stays below one unit of
  // the remainder and the quotient is exact for every f below DEC_SCALE.
  localparam int SHIFT_T = 2 * FW;
  localparam int SHIFT_S = SHIFT_T + FRAC_BITS;
  localparam logic [127:0] RECIP =
    ((128'd1 << SHIFT_S) + 128'(DEC_SCALE) - 128'd1) / 128'(DEC_SCALE);
  localparam int MW = SHIFT_S - FW + 2;
  localparam int ML = MW / 2;
  localparam int MH = MW - ML;
  localparam logic [ML-1:0] RECIP_LO = RECIP[ML-1:0];
  localparam logic [MH-1:0] RECIP_HI = RECIP[MW-1:ML];
  localparam int PW = FW + MW;

  // Handshake.
  logic adv;
  logic in_fire;

  // Running number.
  logic [INT_BITS-1:0] acc_r, acc_nxt;
  logic [FW-1:0]       fs_r, fs_nxt;
  logic [CW-1:0]       fc_r, fc_nxt;
  logic                in_frac_r, in_frac_nxt;
  logic                neg_r, neg_nxt;
  logic                ok_r, ok_nxt;
  logic                sat_r, sat_nxt;
  logic                at_start_r;

  logic [CHAR_W-1:0]     ch;
  logic                  is_digit;
  logic [DIGIT_W-1:0]    digit;
  logic [INT_BITS+3:0]   acc_wide;
  logic [FW-1:0]         place_tab [FRAC_DIGITS];
  logic [FW-1:0]         place;

  // Result pipeline.
  logic                a_valid_r;
  logic [INT_BITS-1:0] a_acc_r;
  logic [FW-1:0]       a_fs_r;
  adfx_flags_t         a_flags_r;

  logic                b_valid_r;
  logic [INT_BITS-1:0] b_acc_r;
  logic [FW+ML-1:0]    b_pp_lo_r;
  logic [FW+MH-1:0]    b_pp_hi_r;
  adfx_flags_t         b_flags_r;

  logic                c_valid_r;
  logic [MAG_W-1:0]    c_mag_r;
  adfx_flags_t         c_flags_r;

  logic [PW-1:0]        prod_sum;
  logic [FRAC_BITS-1:0] frac_bits;

  logic                 out_valid_r;
  logic signed [VW-1:0] out_value_r;
  adfx_flags_t          out_flags_r;

  // The whole pipeline holds while a finished result waits to be taken.
  assign adv = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_fire = in_ch.valid && adv;

  // Weight of each fraction digit position: 10^(FRAC_DIGITS-1-k).
  for (genvar g = 0; g < FRAC_DIGITS; g++) begin : g_place
    assign place_tab[g] = FW'(pow10(FRAC_DIGITS - 1 - g));
  end

  assign ch = in_ch.char_code;
  assign is_digit = ch inside {[CHAR_ZERO:CHAR_NINE]};
  assign digit = is_digit ? DIGIT_W'(ch - CHAR_ZERO) : '0;
  assign place = place_tab[fc_r[IW-1:0]];
  assign acc_wide = ({acc_r, 3'b000} + {2'b00, acc_r, 1'b0}) + (INT_BITS + 4)'(digit);

  // One character updates the running number. A leading minus sets the sign,
  // the first point opens the fraction, everything else is a digit, with
  // non-digits taken as zero and marking the number invalid.
  always_comb begin
    acc_nxt     = acc_r;
    fs_nxt      = fs_r;
    fc_nxt      = fc_r;
    in_frac_nxt = in_frac_r;
    neg_nxt     = neg_r;
    ok_nxt      = ok_r;
    sat_nxt     = sat_r;
    if (at_start_r && (ch == CHAR_MINUS)) begin
      neg_nxt = 1'b1;
    end else if (!in_frac_r && (ch == CHAR_POINT)) begin
      in_frac_nxt = 1'b1;
    end else begin
      if (!is_digit) begin
        ok_nxt = 1'b0;
      end
      if (!in_frac_r) begin
        // Anything above the top integer bit means the new value is too big.
        if (acc_wide[INT_BITS+3:INT_BITS] != 4'd0) begin
          acc_nxt = '1;
          sat_nxt = 1'b1;
        end else begin
          acc_nxt = acc_wide[INT_BITS-1:0];
        end
      end else if (fc_r < CW'(FRAC_DIGITS)) begin
        // Digits beyond the kept ones leave the value alone.
        fs_nxt = FW'(fs_r + digit * place);
        fc_nxt = CW'(fc_r + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      fs_r       <= '0;
      fc_r       <= '0;
      in_frac_r  <= 1'b0;
      neg_r      <= 1'b0;
      ok_r       <= 1'b1;
      sat_r      <= 1'b0;
      at_start_r <= 1'b1;
    end else if (in_fire) begin
      if (in_ch.last_char) begin
        // The number is complete; its values move into the pipeline below.
        acc_r      <= '0;
        fs_r       <= '0;
        fc_r       <= '0;
        in_frac_r  <= 1'b0;
        neg_r      <= 1'b0;
        ok_r       <= 1'b1;
        sat_r      <= 1'b0;
        at_start_r <= 1'b1;
      end else begin
        acc_r      <= acc_nxt;
        fs_r       <= fs_nxt;
        fc_r       <= fc_nxt;
        in_frac_r  <= in_frac_nxt;
        neg_r      <= neg_nxt;
        ok_r       <= ok_nxt;
        sat_r      <= sat_nxt;
        at_start_r <= 1'b0;
      end
    end
  end

  // Sum of the two partial products, then the fraction bits above SHIFT_T.
  assign prod_sum = PW'(b_pp_lo_r) + (PW'(b_pp_hi_r) << ML);
  assign frac_bits = prod_sum[SHIFT_T +: FRAC_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      c_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      a_valid_r   <= in_fire && in_ch.last_char;
      b_valid_r   <= a_valid_r;
      c_valid_r   <= b_valid_r;
      out_valid_r <= c_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage A: the completed number.
      a_acc_r       <= acc_nxt;
      a_fs_r        <= fs_nxt;
      a_flags_r.neg <= neg_nxt;
      a_flags_r.ok  <= ok_nxt;
      a_flags_r.sat <= sat_nxt;
      // Stage B: the reciprocal multiply, split in two halves.
      b_acc_r       <= a_acc_r;
      b_pp_lo_r     <= a_fs_r * RECIP_LO;
      b_pp_hi_r     <= a_fs_r * RECIP_HI;
      b_flags_r     <= a_flags_r;
      // Stage C: magnitude, integer part over the fraction bits.
      c_mag_r       <= {b_acc_r, frac_bits};
      c_flags_r     <= b_flags_r;
      // Output register: apply the sign. A negative zero comes out as zero.
      out_value_r   <= c_flags_r.neg ? VW'(VW'(0) - {1'b0, c_mag_r}) : {1'b0, c_mag_r};
      out_flags_r   <= c_flags_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.value      = out_value_r;
  assign out_ch.is_valid   = out_flags_r.ok;
  assign out_ch.overflowed = out_flags_r.sat;

  // A last character always launches a result into the pipeline.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_char) |=> a_valid_r)
    else $error("last character did not launch a result");

  // The running number starts afresh after each last character.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.last_char) |=>
      (at_start_r && ok_r && !sat_r && !neg_r && !in_frac_r &&
       (acc_r == '0) && (fs_r == '0) && (fc_r == '0)))
    else $error("running number not cleared after a result");

  // No more fraction digits are counted than are kept.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    fc_r <= CW'(FRAC_DIGITS))
    else $error("fraction digit count out of range");

  // Once saturated, the integer part sits at its maximum.
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    sat_r |-> (&acc_r))
    else $error("saturation flag set with integer part below maximum");

endmodule
